### hdl/gcr_pkg.sv
// Shared types and constants for the GF(2) column reduction block.
package gcr_pkg;

    localparam int COL_W     = 64;
    localparam int ROW_OUT_W = 6;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FOLD
    } gcr_state_t;

    typedef struct packed {
        logic load;
        logic fold;
        logic finish;
    } gcr_cmd_t;

    typedef struct packed {
        logic col_zero;
        logic row_taken;
        logic out_busy;
    } gcr_stat_t;

endpackage

### hdl/gf2_column_reduction_dense.sv
// Top level of the dense GF(2) column reduction block.
//
// Input channel (s_): one boundary matrix column per transfer, bit i = row i.
// s_start_matrix set clears the pivot table and column counter first.
// Output channel (m_): one result per column: saturating column index, the
// reduced column, a pivot flag and the pivot row (zero when no pivot).
// Each column is reduced by repeated steps: find its lowest one, read the
// column owning that row from the pivot RAM, XOR it in. Because of the
// registered RAM read, a step spans a scan state and then a fold state.
// One column is in work at a time; the next is taken once the previous result
// is in the output register.
// A result held by a stalled receiver does not block the next transfer in;
// only the hand-off of the following result waits for it.
// Reset (aresetn low, synchronous) empties the pivot table, the counter and
// the output register; pivot RAM contents need no clearing.
module gf2_column_reduction_dense #(
    parameter int MATRIX_SIZE = 64
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [gcr_pkg::COL_W-1:0]     s_column_bits,
    input  logic                          s_start_matrix,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [gcr_pkg::ROW_OUT_W-1:0] m_column_index,
    output logic [gcr_pkg::COL_W-1:0]     m_reduced_bits,
    output logic                          m_has_pivot,
    output logic [gcr_pkg::ROW_OUT_W-1:0] m_pivot_row
);

    gcr_pkg::gcr_cmd_t  cmd;
    gcr_pkg::gcr_stat_t stat;

    gcr_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    gcr_datapath #(
        .MATRIX_SIZE (MATRIX_SIZE)
    ) u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .stat           (stat),
        .s_column_bits  (s_column_bits),
        .s_start_matrix (s_start_matrix),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_column_index (m_column_index),
        .m_reduced_bits (m_reduced_bits),
        .m_has_pivot    (m_has_pivot),
        .m_pivot_row    (m_pivot_row)
    );

endmodule

### hdl/gcr_ram.sv
// Generic single-port RAM with registered read data.
module gcr_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

### hdl/gcr_ctrl.sv
// Controller state machine sequencing load, elimination steps and result hand-off.
module gcr_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  gcr_pkg::gcr_stat_t stat,
    output gcr_pkg::gcr_cmd_t  cmd
);

    gcr_pkg::gcr_state_t state_reg;
    gcr_pkg::gcr_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= gcr_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            gcr_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = gcr_pkg::ST_SCAN;
                end
            end
            gcr_pkg::ST_SCAN: begin
                if (stat.col_zero || !stat.row_taken) begin
                    // hold here until the output register can take the result
                    if (!stat.out_busy) begin
                        cmd.finish = 1'b1;
                        state_next = gcr_pkg::ST_IDLE;
                    end
                end else begin
                    // the RAM reads the owner of the current row this cycle
                    state_next = gcr_pkg::ST_FOLD;
                end
            end
            gcr_pkg::ST_FOLD: begin
                cmd.fold   = 1'b1;
                state_next = gcr_pkg::ST_SCAN;
            end
            default: begin
                state_next = gcr_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

### hdl/gcr_datapath.sv
// Datapath: working column, pivot table, pivot column RAM and output register.
module gcr_datapath #(
    parameter int MATRIX_SIZE = 64
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  gcr_pkg::gcr_cmd_t             cmd,
    output gcr_pkg::gcr_stat_t            stat,
    input  logic [gcr_pkg::COL_W-1:0]     s_column_bits,
    input  logic                          s_start_matrix,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [gcr_pkg::ROW_OUT_W-1:0] m_column_index,
    output logic [gcr_pkg::COL_W-1:0]     m_reduced_bits,
    output logic                          m_has_pivot,
    output logic [gcr_pkg::ROW_OUT_W-1:0] m_pivot_row
);

    localparam int ROW_W = $clog2(MATRIX_SIZE);
    localparam logic [ROW_W-1:0] LAST_INDEX = ROW_W'(MATRIX_SIZE - 1);

    logic [MATRIX_SIZE-1:0] col_reg;
    logic [MATRIX_SIZE-1:0] col_next;
    logic [MATRIX_SIZE-1:0] taken_reg;
    logic [MATRIX_SIZE-1:0] taken_next;
    logic [ROW_W-1:0]       counter_reg;
    logic [ROW_W-1:0]       counter_next;
    logic [ROW_W-1:0]       index_reg;
    logic [ROW_W-1:0]       index_next;
    logic [ROW_W-1:0]       count_base;
    logic [ROW_W-1:0]       low;
    logic [MATRIX_SIZE-1:0] store_rdata;
    logic                   ram_we;
    logic                   col_zero;

    logic                   m_valid_reg;
    logic                   m_valid_next;
    logic [MATRIX_SIZE-1:0] out_bits_reg;
    logic [ROW_W-1:0]       out_index_reg;
    logic                   out_pivot_reg;
    logic [ROW_W-1:0]       out_row_reg;

    // lowest one of the working column: its highest set row
    always_comb begin
        low = '0;
        for (int i = 0; i < MATRIX_SIZE; i++) begin
            if (col_reg[i]) begin
                low = ROW_W'(i);
            end
        end
    end

    assign col_zero      = (col_reg == '0);
    assign stat.col_zero  = col_zero;
    assign stat.row_taken = taken_reg[low];
    assign stat.out_busy  = m_valid_reg && !m_ready;

    assign ram_we = cmd.finish && !col_zero;

    gcr_ram #(
        .WIDTH (MATRIX_SIZE),
        .DEPTH (MATRIX_SIZE)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .addr  (low),
        .wdata (col_reg),
        .rdata (store_rdata)
    );

    assign count_base = s_start_matrix ? '0 : counter_reg;

    always_comb begin
        col_next     = col_reg;
        taken_next   = taken_reg;
        counter_next = counter_reg;
        index_next   = index_reg;
        priority if (cmd.load) begin
            col_next   = s_column_bits[MATRIX_SIZE-1:0];
            index_next = count_base;
            if (s_start_matrix) begin
                taken_next = '0;
            end
            // saturate at the last column of the matrix
            counter_next = (count_base < LAST_INDEX) ? count_base + 1'b1 : count_base;
        end else if (cmd.fold) begin
            col_next = col_reg ^ store_rdata;
        end else if (ram_we) begin
            taken_next[low] = 1'b1;
        end
    end

    assign m_valid_next = cmd.finish || (m_valid_reg && !m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            taken_reg   <= '0;
            counter_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            taken_reg   <= taken_next;
            counter_reg <= counter_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        col_reg   <= col_next;
        index_reg <= index_next;
        if (cmd.finish) begin
            out_bits_reg  <= col_reg;
            out_index_reg <= index_reg;
            out_pivot_reg <= !col_zero;
            out_row_reg   <= col_zero ? '0 : low;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_column_index = gcr_pkg::ROW_OUT_W'(out_index_reg);
    assign m_reduced_bits = gcr_pkg::COL_W'(out_bits_reg);
    assign m_has_pivot    = out_pivot_reg;
    assign m_pivot_row    = gcr_pkg::ROW_OUT_W'(out_row_reg);

endmodule

### tb/gcr_reduction_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the GF(2) column reduction block: predicts every result and checks it.
module gcr_reduction_checker #(
    parameter int MATRIX_SIZE = 64
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    input  logic                          s_ready,
    input  logic [gcr_pkg::COL_W-1:0]     s_column_bits,
    input  logic                          s_start_matrix,
    input  logic                          m_valid,
    input  logic                          m_ready,
    input  logic [gcr_pkg::ROW_OUT_W-1:0] m_column_index,
    input  logic [gcr_pkg::COL_W-1:0]     m_reduced_bits,
    input  logic                          m_has_pivot,
    input  logic [gcr_pkg::ROW_OUT_W-1:0] m_pivot_row,
    output int                            mismatches,
    output int                            columns_accepted,
    output int                            pending,
    output int                            zero_columns,
    output int                            deepest_chain
);

    localparam int COL_W     = gcr_pkg::COL_W;
    localparam int ROW_OUT_W = gcr_pkg::ROW_OUT_W;

    typedef struct packed {
        logic [ROW_OUT_W-1:0] index;
        logic [COL_W-1:0]     bits;
        logic                 has_pivot;
        logic [ROW_OUT_W-1:0] row;
    } reduction_t;

    localparam logic [COL_W-1:0]     ONE        = 1;
    // the shift wraps to zero for a full-width matrix, which leaves all rows set
    localparam logic [COL_W-1:0]     ROW_MASK   = (ONE << MATRIX_SIZE) - ONE;
    localparam logic [ROW_OUT_W-1:0] LAST_INDEX = ROW_OUT_W'(MATRIX_SIZE - 1);

    logic [COL_W-1:0]     owned_rows;
    logic [COL_W-1:0]     owner_column [COL_W];
    logic [ROW_OUT_W-1:0] next_index;
    reduction_t           pending_reductions [$];
    int                   results_seen;

    function automatic int lowest_one_row(input logic [COL_W-1:0] v);
        int r;
        r = 0;
        for (int i = 0; i < COL_W; i++) begin
            if (v[i]) r = i;
        end
        return r;
    endfunction

    function automatic reduction_t reduce_column(input logic [COL_W-1:0] raw,
                                                 input logic start, output int steps);
        reduction_t       res;
        logic [COL_W-1:0] col;
        logic             found;
        int               row;
        col   = raw & ROW_MASK;
        steps = 0;
        found = 1'b0;
        if (start) begin
            owned_rows = '0;
            next_index = '0;
        end
        res.index     = next_index;
        res.has_pivot = 1'b0;
        res.row       = '0;
        if (next_index < LAST_INDEX) next_index++;
        // each fold clears the current lowest one, so this ends within COL_W folds
        while (col != '0 && !found) begin
            row = lowest_one_row(col);
            if (!owned_rows[row]) begin
                found             = 1'b1;
                res.has_pivot     = 1'b1;
                res.row           = row[ROW_OUT_W-1:0];
                owned_rows[row]   = 1'b1;
                owner_column[row] = col;
            end else begin
                col ^= owner_column[row];
                steps++;
            end
        end
        res.bits = col;
        return res;
    endfunction

    task automatic report_mismatch(input string field, input logic [COL_W-1:0] got,
                                   input logic [COL_W-1:0] want);
        $display("%0t ns: result %0d, %s: got %h, want %h",
                 $time, results_seen, field, got, want);
        mismatches++;
    endtask

    always @(posedge aclk) begin
        reduction_t want;
        int         steps;
        if (!aresetn) begin
            owned_rows = '0;
            next_index = '0;
            pending_reductions.delete();
            mismatches       = 0;
            columns_accepted = 0;
            pending          = 0;
            zero_columns     = 0;
            deepest_chain    = 0;
            results_seen     = 0;
        end else begin
            if (s_valid && s_ready) begin
                want = reduce_column(s_column_bits, s_start_matrix, steps);
                pending_reductions.insert(pending_reductions.size(), want);
                columns_accepted++;
                if (steps > deepest_chain) deepest_chain = steps;
            end
            if (m_valid && m_ready) begin
                if (pending_reductions.size() == 0) begin
                    report_mismatch("transfer with no column waiting", m_reduced_bits, '0);
                end else begin
                    want = pending_reductions.pop_front();
                    if (!want.has_pivot) zero_columns++;
                    if (m_column_index != want.index)
                        report_mismatch("column_index", COL_W'(m_column_index),
                                        COL_W'(want.index));
                    if (m_reduced_bits != want.bits)
                        report_mismatch("reduced_bits", m_reduced_bits, want.bits);
                    if (m_has_pivot != want.has_pivot)
                        report_mismatch("has_pivot", COL_W'(m_has_pivot),
                                        COL_W'(want.has_pivot));
                    if (m_pivot_row != want.row)
                        report_mismatch("pivot_row", COL_W'(m_pivot_row),
                                        COL_W'(want.row));
                end
                results_seen++;
            end
            pending = pending_reductions.size();
        end
    end

endmodule

### tb/gf2_column_reduction_dense_test.sv
`timescale 1ns / 100ps
// Stimulus, flow control and verdict for the GF(2) column reduction block.
module gf2_column_reduction_dense_test;

    localparam int COL_W           = gcr_pkg::COL_W;
    localparam int ROW_OUT_W       = gcr_pkg::ROW_OUT_W;
    localparam int MATRIX_SIZE     = 64;
    localparam int COLUMN_TARGET   = 1950;
    localparam int DRAIN_CYCLES    = 2 * MATRIX_SIZE + 12;
    localparam int HOLD_OFF_AT     = 500;
    localparam int HOLD_OFF_CYCLES = 400;

    typedef enum int {
        MIX_NOISE,
        MIX_TRIANGULAR,
        MIX_WINDOW,
        MIX_COMBINE,
        MIX_SPARSE
    } column_mix_t;

    logic                 aclk           = 1'b0;
    logic                 aresetn        = 1'b0;
    logic                 s_valid        = 1'b0;
    logic                 s_ready;
    logic [COL_W-1:0]     s_column_bits  = '0;
    logic                 s_start_matrix = 1'b0;
    logic                 m_valid;
    logic                 m_ready        = 1'b0;
    logic [ROW_OUT_W-1:0] m_column_index;
    logic [COL_W-1:0]     m_reduced_bits;
    logic                 m_has_pivot;
    logic [ROW_OUT_W-1:0] m_pivot_row;

    int   mismatches;
    int   columns_accepted;
    int   results_pending;
    int   zero_columns;
    int   deepest_chain;
    int   columns_sent  = 0;
    int   matrices_sent = 0;
    int   results_taken = 0;
    logic calm_in       = 1'b0;
    logic calm_out      = 1'b0;

    always #6 aclk = ~aclk;

    gf2_column_reduction_dense #(
        .MATRIX_SIZE(MATRIX_SIZE)
    ) u_top (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_column_bits  (s_column_bits),
        .s_start_matrix (s_start_matrix),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_column_index (m_column_index),
        .m_reduced_bits (m_reduced_bits),
        .m_has_pivot    (m_has_pivot),
        .m_pivot_row    (m_pivot_row)
    );

    gcr_reduction_checker #(
        .MATRIX_SIZE(MATRIX_SIZE)
    ) u_check (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_column_bits    (s_column_bits),
        .s_start_matrix   (s_start_matrix),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_column_index   (m_column_index),
        .m_reduced_bits   (m_reduced_bits),
        .m_has_pivot      (m_has_pivot),
        .m_pivot_row      (m_pivot_row),
        .mismatches       (mismatches),
        .columns_accepted (columns_accepted),
        .pending          (results_pending),
        .zero_columns     (zero_columns),
        .deepest_chain    (deepest_chain)
    );

    function automatic logic [COL_W-1:0] wide_random();
        return {$urandom(), $urandom()};
    endfunction

    function automatic logic [COL_W-1:0] rows_below(input int r);
        return (r >= COL_W) ? '1 : ((COL_W'(1) << r) - COL_W'(1));
    endfunction

    task automatic send_column(input logic [COL_W-1:0] bits, input logic start);
        int gap;
        gap = calm_in ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_column_bits  <= bits;
        s_start_matrix <= start;
        s_valid        <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        columns_sent++;
        calm_in = ((columns_sent / 120) % 4) == 2;
    endtask

    // one matrix: a start column, then columns shaped so that eliminations happen
    task automatic send_matrix();
        int               n_cols;
        int               tri_len;
        int               base;
        column_mix_t      mix;
        logic [COL_W-1:0] col;
        logic [COL_W-1:0] earlier [$];
        n_cols  = ($urandom_range(0, 9) == 0) ? $urandom_range(65, 80) : $urandom_range(2, 40);
        mix     = column_mix_t'($urandom_range(0, 4));
        tri_len = (n_cols > COL_W) ? COL_W : (n_cols * 2) / 3;
        base    = $urandom_range(0, COL_W - 8);
        for (int j = 0; j < n_cols; j++) begin
            col = '0;
            unique case (mix)
                MIX_NOISE: begin
                    col = wide_random();
                end
                MIX_TRIANGULAR: begin
                    // own a fresh top row first, then fold deep chains below it
                    if (j < tri_len)
                        col = (COL_W'(1) << j) | (wide_random() & rows_below(j));
                    else
                        col = wide_random() & rows_below(tri_len);
                end
                MIX_WINDOW: begin
                    col = (wide_random() & rows_below(8)) << base;
                end
                MIX_COMBINE: begin
                    if (j >= 2 && $urandom_range(0, 2) != 0) begin
                        col = earlier[$urandom_range(0, j - 1)]
                            ^ earlier[$urandom_range(0, j - 1)];
                        if ($urandom_range(0, 1)) col ^= earlier[$urandom_range(0, j - 1)];
                    end else begin
                        repeat ($urandom_range(1, 3)) col[$urandom_range(0, COL_W - 1)] = 1'b1;
                    end
                end
                default: begin
                    repeat ($urandom_range(1, 3)) col[$urandom_range(0, COL_W - 1)] = 1'b1;
                end
            endcase
            send_column(col, j == 0 || $urandom_range(0, 59) == 0);
            earlier.insert(earlier.size(), col);
        end
        matrices_sent++;
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // zero column on a fresh matrix, then the widest and narrowest pivots
        send_column('0, 1'b1);
        send_column('1, 1'b0);
        send_column(64'h0000_0000_0000_0001, 1'b0);
        send_column(64'h8000_0000_0000_0001, 1'b0);
        send_column(64'h8000_0000_0000_0000, 1'b0);
        // duplicate of an owned column folds down to zero
        send_column('1, 1'b0);
        send_column(64'h5555_5555_5555_5555, 1'b0);
        send_column(64'hAAAA_AAAA_AAAA_AAAA, 1'b0);
        send_column(64'hFFFF_FFFF_0000_0000, 1'b0);
        // restart mid-stream on a nonzero column
        send_column(64'h0000_0000_0000_0003, 1'b1);
        send_column(64'h0000_0000_0000_0002, 1'b0);
        send_column(64'h0000_0000_0000_0001, 1'b0);
        send_column(64'h0000_0000_0000_0003, 1'b0);
        send_column(64'h0000_0000_0000_0004, 1'b0);
        send_column(64'h0000_0000_0000_0007, 1'b0);
        send_column('0, 1'b0);
        matrices_sent = 2;

        while (columns_sent < COLUMN_TARGET) send_matrix();
        s_valid <= 1'b0;

        wait (columns_accepted == columns_sent && results_pending == 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        $display("Covered %0d columns in %0d matrices, incl. runs past the index limit.",
                 columns_sent, matrices_sent);
        $display("%0d columns folded to zero; longest elimination chain was %0d folds.",
                 zero_columns, deepest_chain);
        if (mismatches == 0)
            $display("gf2_column_reduction_dense_test OK");
        else
            $display("gf2_column_reduction_dense_test NOT OK");
        $finish;
    end

    // receiver: random stalls, calm stretches, and one long hold-off that backs up the input
    initial begin
        int wait_cycles;
        do @(posedge aclk); while (!aresetn);
        forever begin
            calm_out    = ((results_taken / 150) % 3) == 1;
            wait_cycles = calm_out ? 0 : $urandom_range(0, 5);
            if (results_taken == HOLD_OFF_AT) wait_cycles = HOLD_OFF_CYCLES;
            if (wait_cycles > 0) begin
                m_ready <= 1'b0;
                repeat (wait_cycles) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!(m_valid && m_ready));
            results_taken++;
        end
    end

    initial begin
        #16_000_000;
        $display("Timeout: %0d of %0d columns accepted, %0d results outstanding",
                 columns_accepted, columns_sent, results_pending);
        $display("gf2_column_reduction_dense_test NOT OK");
        $finish;
    end

endmodule
